[rtl/tmre_pkg.sv]
package tmre_pkg;

  localparam int NBYTES = 17;
  localparam int VAL_W = 11;
  localparam int COORD_LIMIT_DEF = 1024;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_LT = 8'h3c;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_PRESS = 8'h4d;
  localparam logic [7:0] CH_RELEASE = 8'h6d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] LEG_OFS = 8'd32;
  localparam logic [7:0] LEG_SAT = 8'd223;
  localparam logic [7:0] LEG_REL_CODE = 8'd3;

  // one decimal number split into digits
  typedef struct packed {
    logic       thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } dec_t;

  // per-item data that rides beside the digit pipeline
  typedef struct packed {
    logic       sgr;
    logic       rel;
    logic [7:0] leg_code;
    logic [7:0] leg_col;
    logic [7:0] leg_row;
  } side_t;

  // template of byte slots, mask marks slots that go out
  typedef struct packed {
    logic [NBYTES-1:0]      mask;
    logic [NBYTES-1:0][7:0] bytes;
  } report_t;

endpackage

[rtl/tmre_bcd.sv]
module tmre_bcd (
  input  logic                      clk,
  input  logic [3:0]                en,
  input  logic [tmre_pkg::VAL_W-1:0] value,
  output tmre_pkg::dec_t            dec
);
  import tmre_pkg::*;

  logic [VAL_W-1:0] s1_val;
  logic [3:0]       s1_q;
  logic [6:0]       s2_r;
  logic             s2_thou;
  logic [3:0]       s2_hund;
  logic [6:0]       s3_r;
  logic [3:0]       s3_t;
  logic             s3_thou;
  logic [3:0]       s3_hund;

  logic [16:0] prod_q;
  logic [14:0] prod_t;

  // value / 100 by reciprocal, exact for value up to 1024
  assign prod_q = 17'(value) * 17'd41;
  // r / 10 by reciprocal, exact for r below 100
  assign prod_t = 15'(s2_r) * 15'd205;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_val <= value;
      s1_q <= 4'(prod_q >> 12);
    end
    if (en[1]) begin
      s2_r <= 7'(s1_val - VAL_W'(s1_q) * VAL_W'(100));
      s2_thou <= (s1_q >= 4'd10);
      s2_hund <= (s1_q >= 4'd10) ? s1_q - 4'd10 : s1_q;
    end
    if (en[2]) begin
      s3_r <= s2_r;
      s3_t <= 4'(prod_t >> 11);
      s3_thou <= s2_thou;
      s3_hund <= s2_hund;
    end
    if (en[3]) begin
      dec.thou <= s3_thou;
      dec.hund <= s3_hund;
      dec.tens <= s3_t;
      dec.units <= 4'(s3_r - 7'(s3_t) * 7'd10);
    end
  end

endmodule

[rtl/tmre_format.sv]
module tmre_format (
  input  logic              clk,
  input  logic              en,
  input  tmre_pkg::side_t   sd,
  input  tmre_pkg::dec_t    dc,
  input  tmre_pkg::dec_t    dx,
  input  tmre_pkg::dec_t    dy,
  output tmre_pkg::report_t rpt
);
  import tmre_pkg::*;

  report_t rpt_next;

  function automatic logic [7:0] digit(input logic [3:0] d);
    return CH_ZERO | {4'b0, d};
  endfunction

  always_comb begin
    rpt_next = '0;
    rpt_next.bytes[0] = CH_ESC;
    rpt_next.bytes[1] = CH_LBR;
    rpt_next.mask[1:0] = 2'b11;
    if (sd.sgr) begin
      rpt_next.bytes[2] = CH_LT;
      rpt_next.bytes[3] = digit(dc.hund);
      rpt_next.bytes[4] = digit(dc.tens);
      rpt_next.bytes[5] = digit(dc.units);
      rpt_next.bytes[6] = CH_SEMI;
      rpt_next.bytes[7] = digit({3'b0, dx.thou});
      rpt_next.bytes[8] = digit(dx.hund);
      rpt_next.bytes[9] = digit(dx.tens);
      rpt_next.bytes[10] = digit(dx.units);
      rpt_next.bytes[11] = CH_SEMI;
      rpt_next.bytes[12] = digit({3'b0, dy.thou});
      rpt_next.bytes[13] = digit(dy.hund);
      rpt_next.bytes[14] = digit(dy.tens);
      rpt_next.bytes[15] = digit(dy.units);
      rpt_next.bytes[16] = sd.rel ? CH_RELEASE : CH_PRESS;
      // leading zeros are dropped, the units digit always goes out
      rpt_next.mask[2] = 1'b1;
      rpt_next.mask[3] = (dc.hund != 4'd0);
      rpt_next.mask[4] = (dc.hund != 4'd0) || (dc.tens != 4'd0);
      rpt_next.mask[5] = 1'b1;
      rpt_next.mask[6] = 1'b1;
      rpt_next.mask[7] = dx.thou;
      rpt_next.mask[8] = dx.thou || (dx.hund != 4'd0);
      rpt_next.mask[9] = dx.thou || (dx.hund != 4'd0) || (dx.tens != 4'd0);
      rpt_next.mask[10] = 1'b1;
      rpt_next.mask[11] = 1'b1;
      rpt_next.mask[12] = dy.thou;
      rpt_next.mask[13] = dy.thou || (dy.hund != 4'd0);
      rpt_next.mask[14] = dy.thou || (dy.hund != 4'd0) || (dy.tens != 4'd0);
      rpt_next.mask[15] = 1'b1;
      rpt_next.mask[16] = 1'b1;
    end else begin
      rpt_next.bytes[2] = CH_PRESS;
      rpt_next.bytes[3] = sd.leg_code;
      rpt_next.bytes[4] = sd.leg_col;
      rpt_next.bytes[5] = sd.leg_row;
      rpt_next.mask[5:2] = 4'b1111;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rpt <= rpt_next;
    end
  end

endmodule

[rtl/tmre_serial.sv]
module tmre_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tmre_pkg::report_t rpt,
  output logic              can_load,
  output logic              strobe,
  output logic [7:0]        report_byte,
  output logic              last_byte
);
  import tmre_pkg::*;

  logic [NBYTES-1:0]      mask;
  logic [NBYTES-1:0][7:0] bytes;
  logic [NBYTES-1:0]      low;
  logic [7:0]             sel;
  logic                   one_left;

  assign low = mask & (~mask + NBYTES'(1));
  assign one_left = ((mask & (mask - NBYTES'(1))) == '0);
  // empty, or emitting its final byte this cycle
  assign can_load = one_left;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NBYTES; i++) begin
      sel = sel | (bytes[i] & {8{low[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      strobe <= 1'b0;
    end else begin
      mask <= load ? rpt.mask : (mask & ~low);
      strobe <= (mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= rpt.bytes;
    end
    report_byte <= sel;
    last_byte <= one_left;
  end

  assert property (@(posedge clk) disable iff (rst) load |-> one_left)
    else $error("report loaded while bytes remain");
  assert property (@(posedge clk) disable iff (rst) (mask != '0) |=> strobe)
    else $error("pending byte not emitted");
  assert property (@(posedge clk) disable iff (rst)
    ((mask != '0) && !one_left && !load) |=> (mask != '0))
    else $error("report cut short");

endmodule

[rtl/terminal_mouse_report_encoder.sv]
// Mouse report encoder: an event is taken at a clock edge with start high and busy low.
// Bytes appear on report_byte with strobe high, one per cycle, last_byte on the final one;
// the receiver must take every byte as it comes. The first byte passes the front, digit,
// format and serializer registers. A report is 6 bytes in legacy mode and 9 to 17 bytes
// in SGR mode; the single-byte output serializer sets the rate, so reports stream back to
// back, and up to six more events queue before busy rises. The user must write sgr_mode
// via cfg_valid/cfg_data only while no report is in flight; the block does not enforce it.
module terminal_mouse_report_encoder #(
  parameter int COORD_LIMIT = tmre_pkg::COORD_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] button_code,
  input  logic       shift_held,
  input  logic       alt_held,
  input  logic       ctrl_held,
  input  logic       motion,
  input  logic       release_req,
  input  logic [9:0] cell_column,
  input  logic [9:0] cell_row,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  output logic       strobe,
  output logic [7:0] report_byte,
  output logic       last_byte
);
  import tmre_pkg::*;

  localparam logic [13:0] LIM = 14'(COORD_LIMIT);

  logic sgr_mode;

  logic [5:0] vld;
  logic [5:0] rdy;
  logic       can_load;
  logic       accept;

  side_t            side [5];
  side_t            side_next;
  logic [VAL_W-1:0] code_v;
  logic [VAL_W-1:0] col_v;
  logic [VAL_W-1:0] row_v;
  logic [VAL_W-1:0] col_p1;
  logic [VAL_W-1:0] row_p1;
  logic [7:0]       code8;
  logic [7:0]       leg_c;

  dec_t    dc, dx, dy;
  report_t rpt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sgr_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sgr_mode <= cfg_data;
    end
  end

  // stage ready chain, a stage moves when empty or its successor moves
  always_comb begin
    rdy[5] = !vld[5] || can_load;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign busy = !rdy[0];
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= start;
      end
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // front stage: report code, coordinates plus one, legacy bytes
  always_comb begin
    code8 = {1'b0, button_code} + {5'b0, shift_held, 2'b0} + {4'b0, alt_held, 3'b0}
          + {3'b0, ctrl_held, 4'b0} + {2'b0, motion, 5'b0};
    col_p1 = {1'b0, cell_column} + VAL_W'(1);
    row_p1 = {1'b0, cell_row} + VAL_W'(1);
    leg_c = release_req ? LEG_REL_CODE : code8;
    side_next.sgr = sgr_mode;
    side_next.rel = release_req;
    side_next.leg_code = leg_c + LEG_OFS;
    side_next.leg_col = ((col_p1 > VAL_W'(LEG_SAT)) ? LEG_SAT : col_p1[7:0]) + LEG_OFS;
    side_next.leg_row = ((row_p1 > VAL_W'(LEG_SAT)) ? LEG_SAT : row_p1[7:0]) + LEG_OFS;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side[0] <= side_next;
      code_v <= VAL_W'(code8);
      col_v <= (14'(col_p1) > LIM) ? LIM[VAL_W-1:0] : col_p1;
      row_v <= (14'(row_p1) > LIM) ? LIM[VAL_W-1:0] : row_p1;
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  tmre_bcd u_bcd_code (.clk(clk), .en(rdy[4:1]), .value(code_v), .dec(dc));
  tmre_bcd u_bcd_col (.clk(clk), .en(rdy[4:1]), .value(col_v), .dec(dx));
  tmre_bcd u_bcd_row (.clk(clk), .en(rdy[4:1]), .value(row_v), .dec(dy));

  tmre_format u_format (
    .clk(clk),
    .en(rdy[5]),
    .sd(side[4]),
    .dc(dc),
    .dx(dx),
    .dy(dy),
    .rpt(rpt)
  );

  tmre_serial u_serial (
    .clk(clk),
    .rst(rst),
    .load(vld[5] && can_load),
    .rpt(rpt),
    .can_load(can_load),
    .strobe(strobe),
    .report_byte(report_byte),
    .last_byte(last_byte)
  );

  assert property (@(posedge clk) disable iff (rst) accept |=> vld[0])
    else $error("accepted event lost at front stage");
  assert property (@(posedge clk) disable iff (rst) (vld[5] && !rdy[5]) |=> vld[5])
    else $error("stalled report dropped");
  assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !rdy[4]) |=> (vld[4] && $stable(side[4])))
    else $error("stalled stage data changed");

endmodule
